### rtl/cascaded_biquad_equalizer_defines.svh
// Assertion macros for the biquad equalizer.
// Define ASSERT_OFF to compile every check away.
`ifndef CASCADED_BIQUAD_EQUALIZER_DEFINES_SVH
`define CASCADED_BIQUAD_EQUALIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge, masked while reset is high.
`define CBQ_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CBQ_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define CBQ_ASSERT(lbl, ck, rs, prop, msg)
`define CBQ_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

### rtl/cbq_pkg.sv
package cbq_pkg;

  // Field widths
  localparam int SAMPLE_W          = 32;
  localparam int CHAN_W            = 3;
  localparam int IDX_W             = 6;
  localparam int COEF_VAL_W        = 29;
  localparam int SECTION_COUNT_W   = 4;
  localparam int GAIN_W            = 28;
  localparam int PROD_W            = SAMPLE_W + COEF_VAL_W;
  localparam int ACC_W             = 64;
  localparam int COEFS_PER_SECTION = 5;

  // Default sizes
  localparam int DEF_NUM_SECTIONS = 8;
  localparam int DEF_NUM_CHANNELS = 8;

  // Q24 fixed point
  localparam int QBITS = 24;
  localparam logic [GAIN_W-1:0] QONE = GAIN_W'(1) << QBITS;
  localparam logic signed [COEF_VAL_W-1:0] QMAX     = 29'sd134217728;
  localparam logic signed [COEF_VAL_W-1:0] QMAX_NEG = -29'sd134217728;
  localparam logic signed [ACC_W-1:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -64'sd2147483648;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = GAIN_W;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTION_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PREAMP_GAIN   = 1'd1;

  // Coefficient slots within one section
  localparam int SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // idx / 5 as (idx * 13) >> 6, exact for every 6-bit index
  localparam int DIV5_MUL    = 13;
  localparam int DIV5_SHIFT  = 6;
  localparam int DIV5_PROD_W = 10;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic acc_en;
    logic first;
    logic sub;
  } mac_ctrl_t;

  // Arithmetic shift right by QBITS (floor), then saturate to 32 bits
  function automatic logic signed [SAMPLE_W-1:0] sat_shift(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v >>> QBITS;
    if (s > SAT_HI) begin
      sat_shift = SAT_HI[SAMPLE_W-1:0];
    end else if (s < SAT_LO) begin
      sat_shift = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat_shift = s[SAMPLE_W-1:0];
    end
  endfunction

endpackage

### rtl/cbq_if.sv
// Input item channel: a sample to filter or a coefficient word to store
interface cbq_in_if import cbq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [CHAN_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0]   sample_in;
  logic [IDX_W-1:0]             coef_index;
  logic signed [COEF_VAL_W-1:0] coef_value;

  modport source(output valid, mode, channel, sample_in, coef_index, coef_value,
                 input ready);
  modport sink(input valid, mode, channel, sample_in, coef_index, coef_value,
               output ready);
endinterface

// Result channel: one filtered sample
interface cbq_out_if import cbq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source(output valid, channel_out, sample_out, input ready);
  modport sink(input valid, channel_out, sample_out, output ready);
endinterface

### rtl/cbq_mac.sv
// Shared multiplier with a 64-bit accumulator behind it.
// One product per cycle, registered; the accumulator adds or subtracts it.
module cbq_mac import cbq_pkg::*; (
  input  logic                         clk,
  input  logic signed [SAMPLE_W-1:0]   mul_a,
  input  logic signed [COEF_VAL_W-1:0] mul_b,
  input  mac_ctrl_t                    ctrl,
  output logic signed [SAMPLE_W-1:0]   prod_sat,
  output logic signed [SAMPLE_W-1:0]   acc_sat
);

  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  acc;

  // 32 x 29 signed product
  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= prod_c;
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_base = ctrl.first ? '0 : acc;

  // Accumulate; feedback terms are subtracted
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc <= ctrl.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end
  end

  assign prod_sat = sat_shift(prod_ext);
  assign acc_sat  = sat_shift(acc);

endmodule

### rtl/cascaded_biquad_equalizer.sv
// Channel   Dir   Handshake      Payload
// item      in    valid/ready    mode, channel, sample_in, coef_index, coef_value
// result    out   valid/ready    channel_out, sample_out
// cfg       in    cfg_we         cfg_index, cfg_data
//
// A filtered sample runs a preamp multiply, then five multiplies per active
// section through the shared multiplier and the single coefficient read port,
// one multiply per cycle within a section; each section ends in a pipeline
// drain and a history writeback. Bypass samples go straight to the final state;
// coefficient writes are stored without leaving idle. Reset is synchronous and
// leaves all history zero at once. A stalled result holds the next sample in the
// final state until taken; an item is not taken while a sample is in flight.
`include "cascaded_biquad_equalizer_defines.svh"

module cascaded_biquad_equalizer import cbq_pkg::*; #(
  parameter int NUM_SECTIONS = DEF_NUM_SECTIONS,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cbq_in_if.sink                 item,
  cbq_out_if.source              result
);

  localparam int SEC_W     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NUM_COEFS = NUM_SECTIONS * COEFS_PER_SECTION;
  localparam int COEF_AW   = $clog2(NUM_COEFS);
  localparam int NCNT_W    = ($clog2(NUM_SECTIONS + 1) > SECTION_COUNT_W) ?
                             $clog2(NUM_SECTIONS + 1) : SECTION_COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_PRESAT,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

  state_t state;

  // Configuration registers
  logic [SECTION_COUNT_W-1:0] section_count;
  logic [GAIN_W-1:0]          preamp_gain;

  // Sequencer and datapath registers
  logic [CHAN_W-1:0]          ch;
  logic [SEC_W-1:0]           sec;
  logic [COEF_AW-1:0]         coef_addr;
  logic [SLOT_W-1:0]          iss;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic                       s1_vld;
  logic                       s2_vld;
  logic [SLOT_W-1:0]          s1_slot;
  logic [SLOT_W-1:0]          s2_slot;
  logic                       out_valid;
  logic [CHAN_W-1:0]          out_channel;
  logic signed [SAMPLE_W-1:0] out_sample;

  // Memories and their read registers
  logic signed [COEF_VAL_W-1:0] coef_mem [NUM_COEFS];
  logic signed [COEF_VAL_W-1:0] coef_q;
  hist_t                        hist_mem [NUM_SECTIONS][NUM_CHANNELS];
  hist_t                        hist_q;
  logic                         hist_v_q;
  logic [NUM_SECTIONS-1:0][NUM_CHANNELS-1:0] hist_valid;

  // Combinational
  logic [CH_W-1:0]              ch_idx;
  logic [NCNT_W-1:0]            cnt_ext;
  logic [NCNT_W-1:0]            n_eff;
  logic [SEC_W-1:0]             last_sec;
  logic                         bypass;
  logic                         coef_in_range;
  logic                         coef_we;
  logic signed [COEF_VAL_W-1:0] coef_clamped;
  logic [DIV5_PROD_W-1:0]       idx_mul;
  logic [SEC_W-1:0]             wr_sec;
  logic                         accept;
  logic                         drain_done;
  logic                         hist_we;
  hist_t                        hist_new;
  logic signed [SAMPLE_W-1:0]   hx1;
  logic signed [SAMPLE_W-1:0]   hx2;
  logic signed [SAMPLE_W-1:0]   hy1;
  logic signed [SAMPLE_W-1:0]   hy2;
  logic signed [SAMPLE_W-1:0]   operand;
  logic signed [SAMPLE_W-1:0]   mul_a;
  logic signed [COEF_VAL_W-1:0] mul_b;
  mac_ctrl_t                    mac_ctrl;
  logic signed [SAMPLE_W-1:0]   prod_sat;
  logic signed [SAMPLE_W-1:0]   acc_sat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= '0;
      preamp_gain   <= QONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECTION_COUNT: section_count <= cfg_data[SECTION_COUNT_W-1:0];
        REG_PREAMP_GAIN:   preamp_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake; nothing is taken while reset is high
  assign item.ready         = (state == S_IDLE) && !rst;
  assign accept             = item.valid && item.ready;
  assign result.valid       = out_valid;
  assign result.channel_out = out_channel;
  assign result.sample_out  = out_sample;

  // Active section count, clipped to the built sections
  assign cnt_ext  = NCNT_W'(section_count);
  assign n_eff    = (cnt_ext > NCNT_W'(NUM_SECTIONS)) ? NCNT_W'(NUM_SECTIONS) : cnt_ext;
  assign last_sec = SEC_W'(n_eff - 1'b1);
  assign bypass   = (n_eff == '0) || !(int'(item.channel) < NUM_CHANNELS);
  assign ch_idx   = CH_W'(ch);

  // Coefficient write decode
  assign coef_in_range = int'(item.coef_index) < NUM_COEFS;
  assign coef_we       = accept && item.mode && coef_in_range;
  assign coef_clamped  = (item.coef_value > QMAX || item.coef_value < QMAX_NEG) ?
                         '0 : item.coef_value;
  assign idx_mul       = DIV5_PROD_W'(item.coef_index) * DIV5_PROD_W'(DIV5_MUL);
  assign wr_sec        = SEC_W'(idx_mul[DIV5_PROD_W-1:DIV5_SHIFT]);

  // History as read, with cleared entries reading zero
  assign hx1 = hist_v_q ? hist_q.x1 : '0;
  assign hx2 = hist_v_q ? hist_q.x2 : '0;
  assign hy1 = hist_v_q ? hist_q.y1 : '0;
  assign hy2 = hist_v_q ? hist_q.y2 : '0;

  // Data operand for the coefficient now at the multiplier
  always_comb begin
    case (s1_slot)
      SLOT_B0: operand = x_cur;
      SLOT_B1: operand = hx1;
      SLOT_B2: operand = hx2;
      SLOT_A1: operand = hy1;
      SLOT_A2: operand = hy2;
      default: operand = '0;
    endcase
  end

  assign mul_a = (state == S_PRE) ? x_cur : operand;
  assign mul_b = (state == S_PRE) ? $signed({1'b0, preamp_gain}) : coef_q;

  assign mac_ctrl.acc_en = s2_vld;
  assign mac_ctrl.first  = (s2_slot == SLOT_B0);
  assign mac_ctrl.sub    = (s2_slot == SLOT_A1) || (s2_slot == SLOT_A2);

  cbq_mac u_mac (
    .clk      (clk),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .ctrl     (mac_ctrl),
    .prod_sat (prod_sat),
    .acc_sat  (acc_sat)
  );

  // Section writeback once the last product is accumulated
  assign drain_done  = (state == S_DRAIN) && !s1_vld && !s2_vld;
  assign hist_we     = drain_done;
  assign hist_new.x1 = x_cur;
  assign hist_new.x2 = hx1;
  assign hist_new.y1 = acc_sat;
  assign hist_new.y2 = hy1;

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[COEF_AW'(item.coef_index)] <= coef_clamped;
    end
    if (state == S_MAC) begin
      coef_q <= coef_mem[coef_addr];
    end
  end

  // History memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[sec][ch_idx] <= hist_new;
    end
    hist_q   <= hist_mem[sec][ch_idx];
    hist_v_q <= hist_valid[sec][ch_idx];
  end

  // History valid bits: a coefficient write clears its whole section
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (coef_we) begin
      hist_valid[wr_sec] <= '0;
    end else if (hist_we) begin
      hist_valid[sec][ch_idx] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
    end else begin
      s1_vld  <= (state == S_MAC);
      s2_vld  <= s1_vld;
      s1_slot <= iss;
      s2_slot <= s1_slot;
      // result taken; the final state reloads the register itself
      if (result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && !item.mode) begin
            ch        <= item.channel;
            x_cur     <= item.sample_in;
            sec       <= '0;
            coef_addr <= '0;
            iss       <= SLOT_B0;
            state     <= bypass ? S_DONE : S_PRE;
          end
        end
        S_PRE: begin
          state <= S_PRESAT;
        end
        S_PRESAT: begin
          x_cur <= prod_sat;
          state <= S_MAC;
        end
        S_MAC: begin
          coef_addr <= coef_addr + 1'b1;
          iss       <= iss + 1'b1;
          if (iss == SLOT_A2) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            x_cur <= acc_sat;
            iss   <= SLOT_B0;
            if (sec == last_sec) begin
              state <= S_DONE;
            end else begin
              sec   <= sec + 1'b1;
              state <= S_MAC;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_channel <= ch;
            out_sample  <= x_cur;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `CBQ_ASSERT(a_coef_no_result, clk, rst, (accept && item.mode) |=> (state == S_IDLE && !$rose(out_valid)), "coefficient write left idle or produced a result")
  `CBQ_ASSERT(a_sec_in_range, clk, rst, (state == S_MAC) |-> (sec <= last_sec), "section index beyond active count")
  `CBQ_ASSERT(a_pipe_in_filter, clk, rst, s2_vld |-> (state == S_MAC || state == S_DRAIN), "accumulate outside a section pass")
  `CBQ_ASSERT_ALWAYS(a_idle_after_reset, clk, $past(rst) |-> (state == S_IDLE && !out_valid), "not idle after reset")

endmodule

### tb/tb.sv
module tb;
  import cbq_pkg::*;

  localparam int NSEC = DEF_NUM_SECTIONS;
  localparam int NCH = DEF_NUM_CHANNELS;
  localparam int NCOEF = NSEC * COEFS_PER_SECTION;
  localparam int DRAIN_CYCLES = 8 * NSEC + 16;
  localparam int LIMIT = 1000000;
  localparam int HOLD_START = 6000;
  localparam int HOLD_LEN = 400;
  localparam int QUIET_START = 20000;
  localparam int QUIET_END = 35000;
  localparam int RANDOM_ITEMS = 1230;
  localparam int DIR_ROWS = 25;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;
  localparam logic signed [COEF_VAL_W-1:0] C_ONE = 29'sd16777216;
  localparam logic signed [COEF_VAL_W-1:0] C_TOP = 29'sh0FFFFFFF;
  localparam logic signed [COEF_VAL_W-1:0] C_BOT = 29'sh10000000;
  localparam logic [GAIN_W-1:0] G_MAX = '1;
  localparam logic [GAIN_W-1:0] G_TOP = 28'd134217728;

  typedef struct {
    logic                         mode;
    logic [CHAN_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0]   smp;
    logic [IDX_W-1:0]             idx;
    logic signed [COEF_VAL_W-1:0] cval;
  } eq_item_t;

  typedef struct {
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] smp;
  } eq_out_t;

  typedef struct {
    logic [SECTION_COUNT_W-1:0] cnt;
    logic [GAIN_W-1:0]          gain;
    eq_item_t                   it;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cbq_in_if item_if ();
  cbq_out_if result_if ();

  cascaded_biquad_equalizer #(
    .NUM_SECTIONS(NSEC),
    .NUM_CHANNELS(NCH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_if),
    .result(result_if)
  );

  always #5 clk = ~clk;

  // Equalizer state as the predictor sees it
  logic [SECTION_COUNT_W-1:0] eq_count;
  logic [GAIN_W-1:0] eq_gain;
  longint coef_q24 [NCOEF];
  longint x_d1 [NSEC][NCH];
  longint x_d2 [NSEC][NCH];
  longint y_d1 [NSEC][NCH];
  longint y_d2 [NSEC][NCH];

  eq_out_t expected_samples [$];
  int error_count = 0;
  int cycles = 0;
  dir_row_t dir_rows [DIR_ROWS];

  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Predicts one transaction; returns 1 when a filtered sample comes out
  function automatic bit equalize(input eq_item_t it, output eq_out_t r);
    int unsigned sec, n, s, ch;
    longint x, acc, c;
    r.ch = it.channel;
    r.smp = it.smp;
    ch = it.channel;
    if (it.mode == MODE_COEF) begin
      if (it.idx >= NCOEF) return 1'b0;
      c = it.cval;
      // out-of-range coefficients are stored as zero
      if (c > longint'(QMAX) || c < longint'(QMAX_NEG)) c = 0;
      coef_q24[it.idx] = c;
      sec = it.idx / COEFS_PER_SECTION;
      for (s = 0; s < NCH; s++) begin
        x_d1[sec][s] = 0;
        x_d2[sec][s] = 0;
        y_d1[sec][s] = 0;
        y_d2[sec][s] = 0;
      end
      return 1'b0;
    end
    n = (eq_count > NSEC) ? NSEC : eq_count;
    if (n != 0 && ch < NCH) begin
      x = clamp32((longint'(it.smp) * longint'(eq_gain)) >>> QBITS);
      for (s = 0; s < n; s++) begin
        sec = s * COEFS_PER_SECTION;
        acc = coef_q24[sec + SLOT_B0] * x
            + coef_q24[sec + SLOT_B1] * x_d1[s][ch]
            + coef_q24[sec + SLOT_B2] * x_d2[s][ch]
            - coef_q24[sec + SLOT_A1] * y_d1[s][ch]
            - coef_q24[sec + SLOT_A2] * y_d2[s][ch];
        x_d2[s][ch] = x_d1[s][ch];
        x_d1[s][ch] = x;
        x = clamp32(acc >>> QBITS);
        y_d2[s][ch] = y_d1[s][ch];
        y_d1[s][ch] = x;
      end
      r.smp = x[SAMPLE_W-1:0];
    end
    return 1'b1;
  endfunction

  // Coefficient draw: mostly moderate filters, some limits and raw noise
  function automatic logic signed [COEF_VAL_W-1:0] draw_coef(input int slot);
    int span;
    logic signed [COEF_VAL_W-1:0] v;
    span = (slot < SLOT_A1) ? (1 << QBITS) : (1 << (QBITS - 1));
    case ($urandom_range(19))
      0: v = QMAX;
      1: v = QMAX_NEG;
      2: v = QMAX + 29'sd1;
      3: v = QMAX_NEG - 29'sd1;
      4, 5: v = COEF_VAL_W'($urandom);
      default: v = COEF_VAL_W'(int'($urandom_range(0, 2 * span)) - span);
    endcase
    return v;
  endfunction

  function automatic bit quiet_window();
    return cycles >= QUIET_START && cycles < QUIET_END;
  endfunction

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random backpressure, one long hold-off, in-order check
  always @(posedge clk) begin
    eq_out_t want;
    if (cycles >= HOLD_START && cycles < HOLD_START + HOLD_LEN) begin
      result_if.ready <= 1'b0;
    end else if (quiet_window()) begin
      result_if.ready <= 1'b1;
    end else begin
      result_if.ready <= ($urandom_range(99) >= 14);
    end
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: ch %0d sample %0d",
                   result_if.channel_out, result_if.sample_out);
      end else begin
        want = expected_samples.pop_front();
        if (result_if.channel_out !== want.ch) begin
          error_count++;
          if (error_count <= 10)
            $display("channel mismatch: expected %0d got %0d", want.ch,
                     result_if.channel_out);
        end
        if (result_if.sample_out !== want.smp) begin
          error_count++;
          if (error_count <= 10)
            $display("sample mismatch on ch %0d: expected %0d (%h) got %0d (%h)",
                     want.ch, want.smp, want.smp, result_if.sample_out,
                     result_if.sample_out);
        end
      end
    end
  end

  // Offer one transaction, wait for it to be taken, then predict it
  task automatic send_item(input eq_item_t it, input bit typed,
                           input logic signed [SAMPLE_W-1:0] typed_smp);
    eq_out_t r;
    while (!quiet_window() && $urandom_range(99) < 14) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.mode <= it.mode;
    item_if.channel <= it.channel;
    item_if.sample_in <= it.smp;
    item_if.coef_index <= it.idx;
    item_if.coef_value <= it.cval;
    do @(posedge clk); while (!item_if.ready);
    if (equalize(it, r)) begin
      if (typed) r.smp = typed_smp;
      expected_samples.push_back(r);
    end
  endtask

  // Let every outstanding sample come out, then let the block settle
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [SECTION_COUNT_W-1:0] cnt,
                                input logic [GAIN_W-1:0] gain);
    if (cnt == eq_count && gain == eq_gain) return;
    wait_idle();
    if (cnt != eq_count) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_SECTION_COUNT;
      cfg_data <= CFG_DATA_W'(cnt);
      @(posedge clk);
      eq_count = cnt;
    end
    if (gain != eq_gain) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_PREAMP_GAIN;
      cfg_data <= gain;
      @(posedge clk);
      eq_gain = gain;
    end
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed table, full coefficient load, then random phases
  initial begin
    eq_item_t it;
    int i, rand_items, phase_len;
    logic [SECTION_COUNT_W-1:0] cnt;
    logic [GAIN_W-1:0] gain;
    bit first_phase;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_if.valid = 1'b0;
    item_if.mode = MODE_SAMPLE;
    item_if.channel = '0;
    item_if.sample_in = '0;
    item_if.coef_index = '0;
    item_if.coef_value = '0;
    result_if.ready = 1'b0;

    eq_count = '0;
    eq_gain = QONE;
    for (i = 0; i < NCOEF; i++) coef_q24[i] = 0;
    for (i = 0; i < NSEC * NCH; i++) begin
      x_d1[i / NCH][i % NCH] = 0;
      x_d2[i / NCH][i % NCH] = 0;
      y_d1[i / NCH][i % NCH] = 0;
      y_d2[i / NCH][i % NCH] = 0;
    end

    // cnt, gain, {mode, ch, sample, index, coef}, typed, expected sample
    dir_rows = '{
      // bypass after reset: sample passes untouched, preamp ignored
      '{4'd0, QONE, '{MODE_SAMPLE, 3'd7, S_MAX, 6'd0, 29'sd0}, 1'b1, S_MAX},
      '{4'd0, QONE, '{MODE_SAMPLE, 3'd0, S_MIN, 6'd63, -29'sd1}, 1'b1, S_MIN},
      '{4'd0, 28'd0, '{MODE_SAMPLE, 3'd5, -32'sd1, 6'd0, 29'sd0}, 1'b1, -32'sd1},
      // section 0 as a unity pass; too-large words land as zero
      '{4'd0, 28'd0, '{MODE_COEF, 3'd0, 32'sd0, 6'(SLOT_B0), C_ONE}, 1'b0, 32'sd0},
      '{4'd0, 28'd0, '{MODE_COEF, 3'd1, S_MAX, 6'(SLOT_B1), C_TOP}, 1'b0, 32'sd0},
      '{4'd0, 28'd0, '{MODE_COEF, 3'd2, S_MIN, 6'(SLOT_B2), C_BOT}, 1'b0, 32'sd0},
      '{4'd0, 28'd0, '{MODE_COEF, 3'd3, 32'sd0, 6'(SLOT_A1), 29'sd0}, 1'b0, 32'sd0},
      '{4'd0, 28'd0, '{MODE_COEF, 3'd4, 32'sd0, 6'(SLOT_A2), 29'sd0}, 1'b0, 32'sd0},
      // index out of range: ignored
      '{4'd0, 28'd0, '{MODE_COEF, 3'd6, 32'sd0, 6'(NCOEF), C_ONE}, 1'b0, 32'sd0},
      '{4'd0, 28'd0, '{MODE_COEF, 3'd7, 32'sd0, 6'd63, QMAX}, 1'b0, 32'sd0},
      // one unity section, preamp extremes
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd1, 32'sd100, 6'd0, 29'sd0}, 1'b1, 32'sd100},
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd1, S_MIN, 6'd0, 29'sd0}, 1'b1, S_MIN},
      '{4'd1, 28'd0, '{MODE_SAMPLE, 3'd2, 32'sd12345, 6'd0, 29'sd0}, 1'b1, 32'sd0},
      '{4'd1, G_MAX, '{MODE_SAMPLE, 3'd3, S_MAX, 6'd0, 29'sd0}, 1'b1, S_MAX},
      '{4'd1, G_MAX, '{MODE_SAMPLE, 3'd3, S_MIN, 6'd0, 29'sd0}, 1'b1, S_MIN},
      '{4'd1, 28'd1, '{MODE_SAMPLE, 3'd4, S_MAX, 6'd0, 29'sd0}, 1'b1, 32'sd127},
      '{4'd1, 28'd1, '{MODE_SAMPLE, 3'd4, -32'sd1, 6'd0, 29'sd0}, 1'b1, -32'sd1},
      // largest legal taps, feedback drives into saturation
      '{4'd1, QONE, '{MODE_COEF, 3'd5, S_MAX, 6'(SLOT_B1), QMAX}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_COEF, 3'd6, 32'sd0, 6'(SLOT_A1), QMAX_NEG}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd6, 32'sd1000, 6'd0, 29'sd0}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd6, -32'sd5000, 6'd0, 29'sd0}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd6, S_MAX, 6'd0, 29'sd0}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd0, 32'sd7, 6'd0, 29'sd0}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_COEF, 3'd0, 32'sd0, 6'(SLOT_B2), -C_ONE}, 1'b0, 32'sd0},
      '{4'd1, QONE, '{MODE_SAMPLE, 3'd6, 32'sd0, 6'd0, 29'sd0}, 1'b0, 32'sd0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      apply_settings(dir_rows[i].cnt, dir_rows[i].gain);
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    end

    // program every section before any deep cascade runs
    for (i = 0; i < NCOEF; i++) begin
      it.mode = MODE_COEF;
      it.channel = CHAN_W'($urandom_range(NCH - 1));
      it.smp = $urandom;
      it.idx = IDX_W'(i);
      it.cval = draw_coef(i % COEFS_PER_SECTION);
      send_item(it, 1'b0, '0);
    end

    // random phases, each under its own count and gain
    rand_items = 0;
    first_phase = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      if (first_phase) begin
        cnt = 4'd15;
        gain = QONE;
        first_phase = 1'b0;
      end else begin
        case ($urandom_range(11))
          0: cnt = 4'd0;
          1: cnt = 4'd1;
          2, 3: cnt = SECTION_COUNT_W'(NSEC);
          4: cnt = 4'd15;
          5: cnt = SECTION_COUNT_W'($urandom_range(NSEC + 1, 14));
          default: cnt = SECTION_COUNT_W'($urandom_range(1, NSEC - 1));
        endcase
        case ($urandom_range(15))
          0: gain = 28'd0;
          1: gain = 28'd1;
          2: gain = G_MAX;
          3: gain = G_TOP;
          4, 5, 6, 7: gain = QONE;
          default: gain = GAIN_W'($urandom_range(1, 2 * QONE));
        endcase
      end
      apply_settings(cnt, gain);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        it.mode = ($urandom_range(99) < 8) ? MODE_COEF : MODE_SAMPLE;
        it.channel = CHAN_W'($urandom_range(NCH - 1));
        case ($urandom_range(9))
          0: it.smp = S_MAX;
          1: it.smp = S_MIN;
          2, 3, 4: it.smp = int'($urandom_range(0, 131072)) - 65536;
          default: it.smp = $urandom;
        endcase
        if (it.mode == MODE_COEF) begin
          it.idx = IDX_W'(($urandom_range(99) < 85) ? $urandom_range(NCOEF - 1)
                                                    : $urandom_range(NCOEF, 63));
          it.cval = draw_coef(it.idx % COEFS_PER_SECTION);
        end else begin
          it.idx = IDX_W'($urandom);
          it.cval = COEF_VAL_W'($urandom);
        end
        send_item(it, 1'b0, '0);
        rand_items++;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
